// ----- hdl/dlfr_pkg.sv -----
// ----------------------------------------------------------------------------
// dlfr_pkg
// Shared types and constants of the line and frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package dlfr_pkg;

    // Input item commands
    localparam logic [1:0] CMD_BYTE       = 2'd0;
    localparam logic [1:0] CMD_TICK       = 2'd1;
    localparam logic [1:0] CMD_FETCH_LINE = 2'd2;
    localparam logic [1:0] CMD_FETCH_PKT  = 2'd3;

    // Result kinds
    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_LINE   = 2'd1;
    localparam logic [1:0] KIND_PKT    = 2'd2;

    // Register map (word index)
    localparam logic [1:0] REG_START_BYTE = 2'd0;
    localparam logic [1:0] REG_END_BYTE   = 2'd1;
    localparam logic [1:0] REG_IDLE_LIMIT = 2'd2;
    localparam int         APB_AW         = 4;

    localparam logic [7:0]  START_BYTE_RST = 8'hAA;
    localparam logic [7:0]  END_BYTE_RST   = 8'h55;
    localparam logic [15:0] IDLE_LIMIT_RST = 16'd50;

    // Byte classes and frame header
    localparam logic [7:0]  LEN_BIAS  = 8'd5;
    localparam logic [7:0]  PRINT_LO  = 8'h20;
    localparam logic [7:0]  PRINT_HI  = 8'h7F;
    localparam logic [7:0]  CHAR_CR   = 8'h0D;
    localparam logic [7:0]  CHAR_LF   = 8'h0A;
    localparam logic [15:0] SIL_MAX   = 16'hFFFF;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_STATUS,
        ST_STREAM
    } dlfr_state_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic exec;
        logic load_status;
        logic load_data;
    } dlfr_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic stream_go;
        logic out_free;
        logic last_elem;
    } dlfr_stat_t;

endpackage

`default_nettype wire

// ----- hdl/dlfr_if.sv -----
// ----------------------------------------------------------------------------
// dlfr_if
// Valid/ready channels of the line and frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

interface dlfr_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] rx_data;

    modport source (output valid, output command, output rx_data, input ready);
    modport sink   (input valid, input command, input rx_data, output ready);
endinterface

interface dlfr_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] data;
    logic       last;
    logic       line_available;
    logic       packet_available;
    logic       frame_open;

    modport source (output valid, output kind, output data, output last,
                    output line_available, output packet_available,
                    output frame_open, input ready);
    modport sink   (input valid, input kind, input data, input last,
                    input line_available, input packet_available,
                    input frame_open, output ready);
endinterface

`default_nettype wire

// ----- hdl/dlfr_ram.sv -----
// ----------------------------------------------------------------------------
// dlfr_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module dlfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- hdl/dlfr_ctrl.sv -----
// ----------------------------------------------------------------------------
// dlfr_ctrl
// Sequencer: take an item, execute it, then send a status or stream a buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module dlfr_ctrl
    import dlfr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire dlfr_stat_t stat,
    output dlfr_cmd_t       cmd
);

    dlfr_state_t state_reg;
    dlfr_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = stat.stream_go ? ST_STREAM : ST_STATUS;
            end
            ST_STATUS:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_STREAM:
            begin
                if (stat.out_free && stat.last_elem)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready        = 1'b0;
        cmd             = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
            end
            ST_STATUS:
            begin
                cmd.load_status = stat.out_free;
            end
            ST_STREAM:
            begin
                cmd.load_data = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hdl/dlfr_datapath.sv -----
// ----------------------------------------------------------------------------
// dlfr_datapath
// Line and frame state, both buffers, readout index and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dlfr_datapath
    import dlfr_pkg::*;
#(
    parameter int LINE_DEPTH  = 64,
    parameter int FRAME_DEPTH = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire dlfr_cmd_t   cmd,
    output dlfr_stat_t       stat,
    input  wire logic [1:0]  in_command,
    input  wire logic [7:0]  in_rx_data,
    input  wire logic [7:0]  start_byte,
    input  wire logic [7:0]  end_byte,
    input  wire logic [15:0] idle_limit,
    input  wire logic        out_ready,
    output logic             out_valid,
    output logic [1:0]       out_kind,
    output logic [7:0]       out_data,
    output logic             out_last,
    output logic             out_line_available,
    output logic             out_packet_available,
    output logic             out_frame_open
);

    localparam int LCW = $clog2(LINE_DEPTH + 1);
    localparam int LAW = $clog2(LINE_DEPTH);
    localparam int FCW = $clog2(FRAME_DEPTH + 1);
    localparam int FAW = $clog2(FRAME_DEPTH);
    localparam int NW  = (LCW > FCW) ? LCW : FCW;

    localparam logic [FCW-1:0] LEN_POS = FCW'(2);
    localparam logic [FCW-1:0] HDR_LEN = FCW'(3);

    // Item and state registers
    logic [1:0]     cmd_reg;
    logic [7:0]     byte_reg;
    logic [LCW-1:0] line_count_reg, line_count_next;
    logic           line_done_reg, line_done_next;
    logic [FCW-1:0] frame_count_reg, frame_count_next;
    logic           in_frame_reg, in_frame_next;
    logic           frame_done_reg, frame_done_next;
    logic [7:0]     len_reg, len_next;
    logic [15:0]    sil_reg, sil_next;
    logic [NW-1:0]  n_reg, n_next;
    logic [NW-1:0]  idx_reg, idx_next;
    logic [1:0]     kind_reg, kind_next;

    // Output register
    logic           out_valid_reg, out_valid_next;
    logic [1:0]     out_kind_reg, out_kind_next;
    logic [7:0]     out_data_reg, out_data_next;
    logic           out_last_reg, out_last_next;
    logic [2:0]     out_flags_reg, out_flags_next;

    // Buffer ports
    logic           line_wr_en, line_rd_en;
    logic [LAW-1:0] line_rd_addr;
    logic [7:0]     line_rd_data;
    logic           frame_wr_en, frame_rd_en;
    logic [FAW-1:0] frame_rd_addr;
    logic [7:0]     frame_rd_data;

    logic [FCW-1:0] frame_pos, frame_pos_inc;
    logic [7:0]     len_byte, frame_expect;
    logic [15:0]    sil_inc;
    logic [NW-1:0]  idx_plus;
    logic           stream_go, last_elem, out_free;

    assign frame_pos     = in_frame_reg ? frame_count_reg : '0;
    assign frame_pos_inc = frame_pos + FCW'(1);
    assign len_byte      = (frame_pos == LEN_POS) ? byte_reg : len_reg;
    assign frame_expect  = LEN_BIAS + len_byte;
    assign sil_inc       = (sil_reg != SIL_MAX) ? sil_reg + 16'd1 : sil_reg;
    assign idx_plus      = idx_reg + NW'(1);
    assign last_elem     = (idx_plus == n_reg);
    assign out_free      = !out_valid_reg || out_ready;

    always_comb
    begin
        case (cmd_reg)
            CMD_FETCH_LINE: stream_go = line_done_reg && (line_count_reg != '0);
            CMD_FETCH_PKT:  stream_go = frame_done_reg && (frame_count_reg != '0);
            default:        stream_go = 1'b0;
        endcase
    end

    assign stat.stream_go = stream_go;
    assign stat.out_free  = out_free;
    assign stat.last_elem = last_elem;

    // Item execution
    always_comb
    begin
        line_count_next  = line_count_reg;
        line_done_next   = line_done_reg;
        frame_count_next = frame_count_reg;
        in_frame_next    = in_frame_reg;
        frame_done_next  = frame_done_reg;
        len_next         = len_reg;
        sil_next         = sil_reg;
        n_next           = n_reg;
        kind_next        = kind_reg;
        idx_next         = idx_reg;
        line_wr_en       = 1'b0;
        frame_wr_en      = 1'b0;
        if (cmd.exec)
        begin
            idx_next = '0;
            case (cmd_reg)
                CMD_BYTE:
                begin
                    sil_next = '0;
                    if (!frame_done_reg)
                    begin
                        if (!in_frame_reg && (byte_reg != start_byte))
                        begin
                            if (!line_done_reg)
                            begin
                                if ((byte_reg == CHAR_CR) || (byte_reg == CHAR_LF))
                                begin
                                    if (line_count_reg != '0)
                                    begin
                                        line_done_next = 1'b1;
                                    end
                                end
                                else if ((byte_reg >= PRINT_LO) && (byte_reg < PRINT_HI))
                                begin
                                    if (line_count_reg < LCW'(LINE_DEPTH - 1))
                                    begin
                                        line_wr_en      = 1'b1;
                                        line_count_next = line_count_reg + LCW'(1);
                                    end
                                    else
                                    begin
                                        line_count_next = '0;
                                    end
                                end
                            end
                        end
                        else if (frame_pos >= FCW'(FRAME_DEPTH))
                        begin
                            // frame buffer full: abort and drop this byte
                            in_frame_next    = 1'b0;
                            frame_count_next = '0;
                        end
                        else
                        begin
                            frame_wr_en      = 1'b1;
                            in_frame_next    = 1'b1;
                            frame_count_next = frame_pos_inc;
                            if (frame_pos == LEN_POS)
                            begin
                                len_next = byte_reg;
                            end
                            if (frame_pos_inc >= HDR_LEN)
                            begin
                                if ({1'b0, frame_expect} > 9'(FRAME_DEPTH))
                                begin
                                    in_frame_next    = 1'b0;
                                    frame_count_next = '0;
                                end
                                else if (9'(frame_pos_inc) == {1'b0, frame_expect})
                                begin
                                    frame_done_next = (byte_reg == end_byte);
                                    in_frame_next   = 1'b0;
                                end
                            end
                        end
                    end
                end
                CMD_TICK:
                begin
                    sil_next = sil_inc;
                    if (!line_done_reg && (line_count_reg != '0) && !in_frame_reg
                        && (sil_inc >= idle_limit))
                    begin
                        line_done_next = 1'b1;
                    end
                end
                CMD_FETCH_LINE:
                begin
                    if (line_done_reg)
                    begin
                        n_next          = NW'(line_count_reg);
                        kind_next       = KIND_LINE;
                        line_done_next  = 1'b0;
                        line_count_next = '0;
                    end
                end
                CMD_FETCH_PKT:
                begin
                    if (frame_done_reg)
                    begin
                        n_next           = NW'(frame_count_reg);
                        kind_next        = KIND_PKT;
                        frame_done_next  = 1'b0;
                        frame_count_next = '0;
                    end
                end
                default:
                begin
                    sil_next = sil_reg;
                end
            endcase
        end
        else if (cmd.load_data && !last_elem)
        begin
            idx_next = idx_plus;
        end
    end

    // Readout: first address during execution, next one as each byte is sent
    always_comb
    begin
        line_rd_en    = (cmd.exec && stream_go && (cmd_reg == CMD_FETCH_LINE))
                        || (cmd.load_data && !last_elem && (kind_reg == KIND_LINE));
        frame_rd_en   = (cmd.exec && stream_go && (cmd_reg == CMD_FETCH_PKT))
                        || (cmd.load_data && !last_elem && (kind_reg == KIND_PKT));
        line_rd_addr  = cmd.exec ? '0 : idx_plus[LAW-1:0];
        frame_rd_addr = cmd.exec ? '0 : idx_plus[FAW-1:0];
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_kind_next  = out_kind_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        out_flags_next = out_flags_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.load_status || cmd.load_data)
        begin
            out_valid_next = 1'b1;
            out_flags_next = {line_done_reg, frame_done_reg, in_frame_reg};
            if (cmd.load_data)
            begin
                out_kind_next = kind_reg;
                out_data_next = (kind_reg == KIND_LINE) ? line_rd_data : frame_rd_data;
                out_last_next = last_elem;
            end
            else
            begin
                out_kind_next = KIND_STATUS;
                out_data_next = '0;
                out_last_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_count_reg  <= '0;
            line_done_reg   <= 1'b0;
            frame_count_reg <= '0;
            in_frame_reg    <= 1'b0;
            frame_done_reg  <= 1'b0;
            sil_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            line_count_reg  <= line_count_next;
            line_done_reg   <= line_done_next;
            frame_count_reg <= frame_count_next;
            in_frame_reg    <= in_frame_next;
            frame_done_reg  <= frame_done_next;
            sil_reg         <= sil_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cmd_reg  <= in_command;
            byte_reg <= in_rx_data;
        end
        len_reg       <= len_next;
        n_reg         <= n_next;
        idx_reg       <= idx_next;
        kind_reg      <= kind_next;
        out_kind_reg  <= out_kind_next;
        out_data_reg  <= out_data_next;
        out_last_reg  <= out_last_next;
        out_flags_reg <= out_flags_next;
    end

    dlfr_ram #(.WIDTH(8), .DEPTH(LINE_DEPTH)) u_line_ram (
        .clk     (clk),
        .wr_en   (line_wr_en),
        .wr_addr (line_count_reg[LAW-1:0]),
        .wr_data (byte_reg),
        .rd_en   (line_rd_en),
        .rd_addr (line_rd_addr),
        .rd_data (line_rd_data)
    );

    dlfr_ram #(.WIDTH(8), .DEPTH(FRAME_DEPTH)) u_frame_ram (
        .clk     (clk),
        .wr_en   (frame_wr_en),
        .wr_addr (frame_pos[FAW-1:0]),
        .wr_data (byte_reg),
        .rd_en   (frame_rd_en),
        .rd_addr (frame_rd_addr),
        .rd_data (frame_rd_data)
    );

    assign out_valid            = out_valid_reg;
    assign out_kind             = out_kind_reg;
    assign out_data             = out_data_reg;
    assign out_last             = out_last_reg;
    assign out_line_available   = out_flags_reg[2];
    assign out_packet_available = out_flags_reg[1];
    assign out_frame_open       = out_flags_reg[0];

endmodule

`default_nettype wire

// ----- hdl/dual_mode_line_and_frame_receiver.sv -----
// ----------------------------------------------------------------------------
// dual_mode_line_and_frame_receiver
// ASCII line assembler and start/length/end frame assembler on a UART
// byte stream, with idle flush of partial lines and buffered readout.
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake          carries
//   -------  ---  -----------------  -----------------------------------------
//   in_ch    in   valid/ready        command, rx_data
//   out_ch   out  valid/ready        kind, data, last, line/packet/frame flags
//   APB      in   psel/penable/pwr   start_byte @0x0, end_byte @0x4,
//                                    idle_limit @0x8 (pready tied high)
//
// A received byte, a tick or a fetch with nothing ready passes through the
// execute and status states before the next input transaction; its status
// result is loaded into the output register as the status state is left.
// A fetch of a ready line or packet passes through the execute state and then
// streams the buffer; the buffer RAM read port delivers one byte per cycle
// while out_ch.ready does not stall it. Input is taken only between items;
// the output register lets a new transaction in while the last result still
// waits on out_ch.ready. A stall on out_ch.ready holds the readout at the
// current byte. Reset clears all control state; buffer RAMs need no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_mode_line_and_frame_receiver
    import dlfr_pkg::*;
#(
    parameter int LINE_DEPTH  = 64,
    parameter int FRAME_DEPTH = 64
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    // configuration port
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready,
    // item channels
    dlfr_in_if.sink                in_ch,
    dlfr_out_if.source             out_ch
);

    logic [7:0]  start_byte_reg;
    logic [7:0]  end_byte_reg;
    logic [15:0] idle_limit_reg;
    logic        cfg_write;
    logic [1:0]  cfg_index;

    dlfr_cmd_t   cmd;
    dlfr_stat_t  stat;

    // Register file: write on the access phase, read back any time
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[APB_AW-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg <= START_BYTE_RST;
            end_byte_reg   <= END_BYTE_RST;
            idle_limit_reg <= IDLE_LIMIT_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_START_BYTE: start_byte_reg <= pwdata[7:0];
                REG_END_BYTE:   end_byte_reg   <= pwdata[7:0];
                REG_IDLE_LIMIT: idle_limit_reg <= pwdata[15:0];
                default:        start_byte_reg <= start_byte_reg;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_index)
            REG_START_BYTE: prdata = {24'd0, start_byte_reg};
            REG_END_BYTE:   prdata = {24'd0, end_byte_reg};
            REG_IDLE_LIMIT: prdata = {16'd0, idle_limit_reg};
            default:        prdata = '0;
        endcase
    end

    // Sequencer: one item at a time
    dlfr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Assembly state, buffers and result register
    dlfr_datapath #(
        .LINE_DEPTH  (LINE_DEPTH),
        .FRAME_DEPTH (FRAME_DEPTH)
    ) u_datapath (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cmd                  (cmd),
        .stat                 (stat),
        .in_command           (in_ch.command),
        .in_rx_data           (in_ch.rx_data),
        .start_byte           (start_byte_reg),
        .end_byte             (end_byte_reg),
        .idle_limit           (idle_limit_reg),
        .out_ready            (out_ch.ready),
        .out_valid            (out_ch.valid),
        .out_kind             (out_ch.kind),
        .out_data             (out_ch.data),
        .out_last             (out_ch.last),
        .out_line_available   (out_ch.line_available),
        .out_packet_available (out_ch.packet_available),
        .out_frame_open       (out_ch.frame_open)
    );

endmodule

`default_nettype wire

// ----- hdl/dlfr_checker.sv -----
// ----------------------------------------------------------------------------
// dlfr_checker
// Port-level checks of the line and frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dlfr_checker
    import dlfr_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [1:0] out_kind,
    input wire logic [7:0] out_data,
    input wire logic       out_last,
    input wire logic       line_available,
    input wire logic       packet_available,
    input wire logic       frame_open
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_kind)
            && $stable(out_data) && $stable(out_last))
        else $error("result changed while stalled");

    // One item at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while an item is in progress");

    // Status result is a lone, empty final result
    a_status_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_kind == KIND_STATUS) |-> out_last && (out_data == 8'd0))
        else $error("malformed status result");

    // Streamed buffer is already released
    a_fetch_clears: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !((out_kind == KIND_LINE) && line_available)
            && !((out_kind == KIND_PKT) && packet_available))
        else $error("buffer still flagged during its readout");

    // A ready packet blocks frame assembly
    a_pkt_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(packet_available && frame_open))
        else $error("frame open while a packet is ready");

endmodule

bind dual_mode_line_and_frame_receiver dlfr_checker u_dlfr_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_ch.valid),
    .in_ready         (in_ch.ready),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_kind         (out_ch.kind),
    .out_data         (out_ch.data),
    .out_last         (out_ch.last),
    .line_available   (out_ch.line_available),
    .packet_available (out_ch.packet_available),
    .frame_open       (out_ch.frame_open)
);

`default_nettype wire

// ----- tb/dlfr_tb_pkg.sv -----
// ----------------------------------------------------------------------------
// dlfr_tb_pkg
// Result scoreboard for the line and frame receiver: it mirrors the line
// assembler, the frame assembler and the silence counter, predicts every
// result of each accepted transaction and compares what comes out.
// ----------------------------------------------------------------------------
`default_nettype none

package dlfr_tb_pkg;

    import dlfr_pkg::*;

    localparam int LINE_SLOTS  = 64;
    localparam int FRAME_SLOTS = 64;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       last;
        logic       line_available;
        logic       packet_available;
        logic       frame_open;
    } rx_result_t;

    class rx_scoreboard;

        // register copies
        logic [7:0]  start_b;
        logic [7:0]  end_b;
        logic [15:0] idle_lim;

        // receiver state
        logic [7:0]  line_mem [LINE_SLOTS];
        int          line_cnt;
        bit          line_rdy;
        logic [7:0]  frame_mem [FRAME_SLOTS];
        int          frame_cnt;
        bit          frame_act;
        bit          frame_rdy;
        logic [15:0] quiet_ticks;

        rx_result_t  expected_q [$];
        int          errors;

        function new();
            start_b     = START_BYTE_RST;
            end_b       = END_BYTE_RST;
            idle_lim    = IDLE_LIMIT_RST;
            line_cnt    = 0;
            line_rdy    = 1'b0;
            frame_cnt   = 0;
            frame_act   = 1'b0;
            frame_rdy   = 1'b0;
            quiet_ticks = '0;
            errors      = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                REG_START_BYTE: start_b  = val[7:0];
                REG_END_BYTE:   end_b    = val[7:0];
                REG_IDLE_LIMIT: idle_lim = val[15:0];
                default: ;
            endcase
        endfunction

        function void rx_byte(logic [7:0] b);
            logic [7:0] want_len;
            quiet_ticks = '0;
            if (frame_rdy)
                return;
            if (!frame_act && b != start_b) begin
                if (line_rdy)
                    return;
                if (b == CHAR_CR || b == CHAR_LF) begin
                    if (line_cnt > 0)
                        line_rdy = 1'b1;
                end else if (b >= PRINT_LO && b < PRINT_HI) begin
                    // a full line is thrown away, together with the new byte
                    if (line_cnt < LINE_SLOTS - 1) begin
                        line_mem[line_cnt] = b;
                        line_cnt++;
                    end else begin
                        line_cnt = 0;
                    end
                end
                return;
            end
            if (!frame_act) begin
                frame_cnt = 0;
                frame_act = 1'b1;
            end
            if (frame_cnt >= FRAME_SLOTS) begin
                frame_act = 1'b0;
                frame_cnt = 0;
                return;
            end
            frame_mem[frame_cnt] = b;
            frame_cnt++;
            if (frame_cnt >= 3) begin
                want_len = LEN_BIAS + frame_mem[2];   // wraps at 8 bits
                if (want_len > FRAME_SLOTS) begin
                    frame_act = 1'b0;
                    frame_cnt = 0;
                    return;
                end
                if (frame_cnt == want_len) begin
                    if (frame_mem[frame_cnt-1] == end_b)
                        frame_rdy = 1'b1;
                    frame_act = 1'b0;
                end
            end
        endfunction

        function void rx_tick();
            if (quiet_ticks != SIL_MAX)
                quiet_ticks++;
            if (line_rdy || line_cnt == 0 || frame_act)
                return;
            if (quiet_ticks < idle_lim)
                return;
            line_rdy = 1'b1;
        endfunction

        // Advance the state by one accepted transaction and queue its results.
        function void note_input(logic [1:0] cmd, logic [7:0] b);
            logic [7:0] dump [$];
            logic [1:0] k;
            rx_result_t r;
            k = KIND_STATUS;
            case (cmd)
                CMD_BYTE: rx_byte(b);
                CMD_TICK: rx_tick();
                CMD_FETCH_LINE:
                    if (line_rdy) begin
                        for (int i = 0; i < line_cnt; i++)
                            dump.push_back(line_mem[i]);
                        k        = KIND_LINE;
                        line_rdy = 1'b0;
                        line_cnt = 0;
                    end
                CMD_FETCH_PKT:
                    if (frame_rdy) begin
                        for (int i = 0; i < frame_cnt; i++)
                            dump.push_back(frame_mem[i]);
                        k         = KIND_PKT;
                        frame_rdy = 1'b0;
                        frame_cnt = 0;
                    end
                default: ;
            endcase
            if (dump.size() == 0) begin
                k = KIND_STATUS;
                dump.push_back(8'h00);
            end
            foreach (dump[i]) begin
                r.kind             = k;
                r.data             = dump[i];
                r.last             = (i == dump.size() - 1);
                r.line_available   = line_rdy;
                r.packet_available = frame_rdy;
                r.frame_open       = frame_act;
                expected_q.push_back(r);
            end
        endfunction

        function void mismatch(string field, int want, int got);
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        endfunction

        function void check_result(rx_result_t got);
            rx_result_t want;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                return;
            end
            want = expected_q.pop_front();
            if (got.kind != want.kind)
                mismatch("kind", want.kind, got.kind);
            if (got.data != want.data)
                mismatch("data", want.data, got.data);
            if (got.last != want.last)
                mismatch("last", want.last, got.last);
            if (got.line_available != want.line_available)
                mismatch("line_available", want.line_available, got.line_available);
            if (got.packet_available != want.packet_available)
                mismatch("packet_available", want.packet_available, got.packet_available);
            if (got.frame_open != want.frame_open)
                mismatch("frame_open", want.frame_open, got.frame_open);
        endfunction

    endclass

endpackage

`default_nettype wire

// ----- tb/dual_mode_line_and_frame_receiver_test.sv -----
// ----------------------------------------------------------------------------
// dual_mode_line_and_frame_receiver_test
// Drives bytes, ticks and fetch requests into the receiver under several
// register settings, with random stalls on both channels, and checks every
// result against a scoreboard that tracks the line and frame state.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_mode_line_and_frame_receiver_test;

    timeunit 1ns;
    timeprecision 1ps;

    import dlfr_pkg::*;
    import dlfr_tb_pkg::*;

    // Generous cycle budget, far above a run in which every fetch streams a
    // full buffer under the longest stalls.
    localparam int CYCLE_LIMIT = 3_000_000;
    // Length of the long receiver hold-off, in cycles.
    localparam int HOLD_CYCLES = 300;

    logic clk = 1'b0;
    logic rst_n;

    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    dlfr_in_if  in_ch ();
    dlfr_out_if out_ch ();

    dual_mode_line_and_frame_receiver dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    rx_scoreboard sb = new();
    rx_result_t   got;

    bit idle_on       = 1'b0;   // random stalls allowed on both sides
    bit hold_off_req  = 1'b0;   // ask the sink for one long hold-off
    int items_sent    = 0;
    int cycle_count   = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Monitor: note each input transaction and check each result at the
    // rising edge, where every driven signal has been stable since the falling edge.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && in_ch.valid && in_ch.ready)
            sb.note_input(in_ch.command, in_ch.rx_data);
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got.kind             = out_ch.kind;
            got.data             = out_ch.data;
            got.last             = out_ch.last;
            got.line_available   = out_ch.line_available;
            got.packet_available = out_ch.packet_available;
            got.frame_open       = out_ch.frame_open;
            sb.check_result(got);
        end
    end

    // ------------------------------------------------------------------------
    // Sink side: ready drops in random bursts, and once on request for a long
    // stretch so that the block backs up into its input channel.
    // ------------------------------------------------------------------------
    initial
    begin : sink_ready
        int n;
        out_ch.ready = 1'b1;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_off_req = 1'b0;
                out_ch.ready <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                out_ch.ready <= 1'b0;
                n = $urandom_range(1, 11);
                repeat (n) @(negedge clk);
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run if it hangs.
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Driver tasks. Each one is entered and left at a falling edge. valid
    // stays high from one transaction to the next; only a gap or a drain
    // lowers it, so it never gets two updates in one time step.
    // ------------------------------------------------------------------------
    task automatic send_item(input logic [1:0] cmd, input logic [7:0] b);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 11);
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.command <= cmd;
        in_ch.rx_data <= b;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    // Drop valid and wait until every predicted result has come out.
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // APB write: setup cycle, then access cycle until pready. The upper bits
    // of pwdata carry noise that the register must ignore.
    task automatic reg_write(input logic [1:0] idx, input logic [15:0] val);
        logic [31:0] word;
        word    = {16'($urandom_range(0, 65535)), val};
        if (idx != REG_IDLE_LIMIT)
            word[15:8] = 8'($urandom_range(0, 255));
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.set_reg(idx, word);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_regs(input logic [7:0] sb_val, input logic [7:0] eb_val,
                            input logic [15:0] lim);
        reg_write(REG_START_BYTE, {8'h00, sb_val});
        reg_write(REG_END_BYTE, {8'h00, eb_val});
        reg_write(REG_IDLE_LIMIT, lim);
    endtask

    // Printable characters with the odd control byte mixed in; ending 0 is
    // CR, 1 is LF, anything else leaves the line open for an idle flush.
    task automatic send_line(input int n, input int ending);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 15) == 0)
                send_item(CMD_BYTE, 8'($urandom_range(0, 31)));
            send_item(CMD_BYTE, 8'($urandom_range(PRINT_LO, PRINT_HI - 1)));
        end
        if (ending == 0)
            send_item(CMD_BYTE, CHAR_CR);
        else if (ending == 1)
            send_item(CMD_BYTE, CHAR_LF);
    endtask

    // Start byte, one free header byte, the length byte, then the body.
    task automatic send_frame(input logic [7:0] len_field, input bit good_end);
        logic [7:0] want;
        int body;
        want = LEN_BIAS + len_field;
        if (want > FRAME_SLOTS)
            body = 0;                   // aborted on the length byte
        else if (want < 3)
            body = FRAME_SLOTS - 2;     // wrapped length: run into overflow
        else
            body = want - 3;
        send_item(CMD_BYTE, sb.start_b);
        send_item(CMD_BYTE, 8'($urandom_range(0, 255)));
        send_item(CMD_BYTE, len_field);
        for (int i = 0; i < body; i++)
            send_item(CMD_BYTE, (good_end && i == body - 1) ? sb.end_b
                                                             : 8'($urandom_range(0, 255)));
    endtask

    task automatic random_episode();
        int pick;
        int n;
        logic [7:0] len_field;
        pick = $urandom_range(0, 99);
        if (pick < 30)
        begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(61, 66) : $urandom_range(1, 12);
            send_line(n, $urandom_range(0, 2));
            if ($urandom_range(0, 1))
                send_item(CMD_FETCH_LINE, 8'($urandom_range(0, 255)));
        end
        else if (pick < 60)
        begin
            n = $urandom_range(0, 19);
            if (n < 13)
                len_field = 8'(n);
            else if (n < 15)
                len_field = 8'd59;                          // longest legal frame
            else if (n == 15)
                len_field = 8'($urandom_range(60, 250));    // too long
            else if (n < 18)
                len_field = 8'($urandom_range(251, 255));   // wrapped length
            else
                len_field = 8'($urandom_range(0, 255));
            send_frame(len_field, $urandom_range(0, 4) != 0);
            if ($urandom_range(0, 9) < 7)
                send_item(CMD_FETCH_PKT, 8'($urandom_range(0, 255)));
        end
        else if (pick < 75)
        begin
            n = (sb.idle_lim < 8) ? $urandom_range(1, sb.idle_lim + 2) : $urandom_range(1, 4);
            repeat (n) send_item(CMD_TICK, 8'($urandom_range(0, 255)));
        end
        else if (pick < 85)
        begin
            send_item($urandom_range(0, 1) ? CMD_FETCH_LINE : CMD_FETCH_PKT,
                      8'($urandom_range(0, 255)));
        end
        else
        begin
            n = $urandom_range(1, 4);
            repeat (n) send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic run_random(input int count, input bit allow_idle);
        int goal;
        goal = items_sent + count;
        while (items_sent < goal)
        begin
            // leave some episodes free of stalls on both sides
            idle_on = allow_idle && ($urandom_range(0, 3) != 0);
            random_episode();
        end
    endtask

    // Bring the receiver to an empty line, no frame and nothing pending.
    task automatic settle();
        while (sb.frame_act || sb.frame_rdy || sb.line_rdy)
        begin
            if (sb.frame_rdy)
                send_item(CMD_FETCH_PKT, 8'h00);
            else if (sb.line_rdy)
                send_item(CMD_FETCH_LINE, 8'h00);
            else
                send_item(CMD_BYTE, 8'h00);
        end
        if (sb.line_cnt > 0)
        begin
            send_item(CMD_BYTE, CHAR_CR);
            send_item(CMD_FETCH_LINE, 8'h00);
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : main_seq
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        in_ch.valid   = 1'b0;
        in_ch.command = CMD_BYTE;
        in_ch.rx_data = 8'h00;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part at reset register values.
        idle_on = 1'b0;
        send_item(CMD_FETCH_LINE, 8'hFF);    // nothing ready: one status result
        send_item(CMD_FETCH_PKT, 8'h00);
        send_item(CMD_BYTE, "H");
        send_item(CMD_BYTE, "i");
        send_item(CMD_BYTE, CHAR_CR);
        send_item(CMD_BYTE, "x");            // ignored while the line waits
        send_item(CMD_FETCH_LINE, 8'h00);
        send_item(CMD_BYTE, CHAR_LF);        // empty line end: no change
        send_item(CMD_BYTE, 8'h7F);          // non-printable bytes are dropped
        send_item(CMD_BYTE, 8'h00);
        send_item(CMD_BYTE, 8'hFF);
        send_item(CMD_BYTE, PRINT_LO);       // printable range edges
        send_item(CMD_BYTE, PRINT_HI - 8'd1);
        send_item(CMD_BYTE, CHAR_LF);
        send_item(CMD_FETCH_LINE, 8'h00);
        // good five-byte frame, a byte blocked while it waits, then readout
        send_item(CMD_BYTE, START_BYTE_RST);
        send_item(CMD_BYTE, 8'h01);
        send_item(CMD_BYTE, 8'h00);
        send_item(CMD_BYTE, 8'h33);
        send_item(CMD_BYTE, END_BYTE_RST);
        send_item(CMD_BYTE, "A");
        send_item(CMD_FETCH_PKT, 8'h00);
        // bad end byte: frame closes, nothing to fetch
        send_item(CMD_BYTE, START_BYTE_RST);
        repeat (4) send_item(CMD_BYTE, 8'h00);
        send_item(CMD_FETCH_PKT, 8'h00);
        drain();

        // Low extremes, immediate idle flush.
        set_regs(8'h00, 8'hFF, 16'd0);
        run_random(40, 1'b1);
        drain();

        // High extremes, short idle limit, and a long hold-off on the sink.
        set_regs(8'hFF, 8'h00, 16'd3);
        hold_off_req = 1'b1;
        repeat (12) send_item(CMD_TICK, 8'($urandom_range(0, 255)));
        run_random(50, 1'b1);
        drain();

        // Random settings.
        set_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 16'($urandom_range(1, 8)));
        run_random(50, 1'b1);
        drain();

        // Last part, no stalls: printable start byte, top idle limit, then a
        // partial line that a short silence leaves pending.
        idle_on = 1'b0;
        set_regs(8'h7E, 8'($urandom_range(0, 255)), 16'hFFFF);
        run_random(30, 1'b0);
        settle();
        send_item(CMD_BYTE, "Z");
        repeat (6) send_item(CMD_TICK, 8'($urandom_range(0, 255)));
        send_item(CMD_FETCH_LINE, 8'h00);

        drain();
        repeat (2 * LINE_SLOTS + 10) @(negedge clk);

        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire
